// ===== hw/rtl/deque_with_keyed_delete_core_assert.svh =====
// ----------------------------------------------------------------------------
// deque_with_keyed_delete_core assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_KEYED_DELETE_CORE_ASSERT_SVH
`define DEQUE_WITH_KEYED_DELETE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define DQKD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DQKD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define DQKD_ASSERT(name, clk, rst_n, prop, msg)
`define DQKD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/dqkd_pkg.sv =====
// ----------------------------------------------------------------------------
// dqkd_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package dqkd_pkg;

    localparam int DQKD_DEPTH      = 16;
    localparam int DQKD_ITEM_WIDTH = 32;
    localparam int OPCODE_W        = 3;
    localparam int STATUS_W        = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PREPEND = 3'd0,
        OP_APPEND  = 3'd1,
        OP_DEQUEUE = 3'd2,
        OP_DELETE  = 3'd3,
        OP_SEARCH  = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEQ_WAIT,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } ctrl_state_t;

    // read address source
    typedef enum logic [1:0] {
        RD_FRONT,
        RD_NEXT,
        RD_SKIP
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PREPEND,
        WR_APPEND,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        SCAN_HOLD,
        SCAN_START,
        SCAN_STEP
    } scan_op_t;

    typedef struct packed {
        logic     load_in;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        ptr_op_t  front_op;
        ptr_op_t  count_op;
        scan_op_t scan_op;
        logic     res_set;
        status_t  res_status;
        logic     res_take_item;
        logic     out_load;
    } dqkd_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                full;
        logic                empty;
        logic                match;
        logic                last_scan;
        logic                last_shift;
        logic                out_free;
    } dqkd_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dqkd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqkd_ctrl
// command sequencer: decodes one command and steps the datapath through it
// ----------------------------------------------------------------------------
`default_nettype none

`include "deque_with_keyed_delete_core_assert.svh"

module dqkd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire dqkd_pkg::dqkd_sts_t sts,
    output dqkd_pkg::dqkd_cmd_t     cmd
);
    import dqkd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        s_tready          = 1'b0;
        cmd.load_in       = 1'b0;
        cmd.rd_sel        = RD_FRONT;
        cmd.wr_sel        = WR_NONE;
        cmd.front_op      = PTR_HOLD;
        cmd.count_op      = PTR_HOLD;
        cmd.scan_op       = SCAN_HOLD;
        cmd.res_set       = 1'b0;
        cmd.res_status    = ST_MISS;
        cmd.res_take_item = 1'b0;
        cmd.out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (sts.opcode)
                    OP_PREPEND, OP_APPEND:
                    begin
                        cmd.res_set = 1'b1;
                        if (sts.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.res_status = ST_OK;
                            cmd.count_op   = PTR_INC;
                            if (sts.opcode == OP_PREPEND)
                            begin
                                cmd.wr_sel   = WR_PREPEND;
                                cmd.front_op = PTR_DEC;
                            end
                            else
                            begin
                                cmd.wr_sel = WR_APPEND;
                            end
                        end
                        state_next = S_RESULT;
                    end
                    OP_DEQUEUE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_set = 1'b1;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_FRONT;
                            state_next = S_DEQ_WAIT;
                        end
                    end
                    OP_DELETE, OP_SEARCH:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_set = 1'b1;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            cmd.rd_sel  = RD_FRONT;
                            cmd.scan_op = SCAN_START;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_set = 1'b1;
                        state_next  = S_RESULT;
                    end
                endcase
            end

            S_DEQ_WAIT:
            begin
                cmd.res_set       = 1'b1;
                cmd.res_status    = ST_OK;
                cmd.res_take_item = 1'b1;
                cmd.front_op      = PTR_INC;
                cmd.count_op      = PTR_DEC;
                state_next        = S_RESULT;
            end

            S_SCAN:
            begin
                // prefetch the next entry; on a delete hit it feeds the first shift
                cmd.rd_sel = RD_NEXT;
                if (sts.match)
                begin
                    if (sts.opcode == OP_SEARCH)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = S_RESULT;
                    end
                    else if (sts.last_scan)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.count_op   = PTR_DEC;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (sts.last_scan)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.scan_op = SCAN_STEP;
                end
            end

            S_SHIFT:
            begin
                cmd.wr_sel  = WR_SHIFT;
                cmd.rd_sel  = RD_SKIP;
                cmd.scan_op = SCAN_STEP;
                if (sts.last_shift)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.count_op   = PTR_DEC;
                    state_next     = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DQKD_ASSERT_IMPL(a_scan_nonempty, clk, rst_n, state_reg == S_SCAN, !sts.empty, "scan of an empty store")
    `DQKD_ASSERT_IMPL(a_shift_not_tail, clk, rst_n, state_reg == S_SHIFT, !sts.last_scan, "shift past the tail")

endmodule

`default_nettype wire

// ===== hw/rtl/dqkd_datapath.sv =====
// ----------------------------------------------------------------------------
// dqkd_datapath
// entry memory, front/count pointers, scan cursor and output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "deque_with_keyed_delete_core_assert.svh"

module dqkd_datapath #(
    parameter int DEPTH      = dqkd_pkg::DQKD_DEPTH,
    parameter int ITEM_WIDTH = dqkd_pkg::DQKD_ITEM_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [((dqkd_pkg::OPCODE_W+ITEM_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire dqkd_pkg::dqkd_cmd_t cmd,
    output dqkd_pkg::dqkd_sts_t      sts,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status, item_out, length from bit 0 up
    output logic [((dqkd_pkg::STATUS_W+ITEM_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);
    import dqkd_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int OUT_W  = ((STATUS_W + ITEM_WIDTH + CNT_W + 7) / 8) * 8;

    logic [ITEM_WIDTH-1:0] store_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] rdata_reg;

    logic [OPCODE_W-1:0]   op_reg;
    logic [ITEM_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    status_t               res_status_reg;
    logic [ITEM_WIDTH-1:0] res_item_reg;
    status_t               out_status_reg;
    logic [ITEM_WIDTH-1:0] out_item_reg;
    logic [CNT_W-1:0]      out_length_reg;
    logic                  m_tvalid_reg;

    logic [IDX_W-1:0]      front_inc, front_dec, cur_inc, cur_inc2, tail_slot;
    logic [SUM_W-1:0]      tail_sum;
    logic [CNT_W:0]        pos_p1, pos_p2;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  wr_en;
    logic                  full, out_free;

    // circular index arithmetic, correct for any depth
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign cur_inc   = (cur_reg == IDX_W'(DEPTH - 1)) ? '0 : cur_reg + 1'b1;
    assign cur_inc2  = (cur_inc == IDX_W'(DEPTH - 1)) ? '0 : cur_inc + 1'b1;
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                   : tail_sum[IDX_W-1:0];

    assign pos_p1 = (CNT_W+1)'(pos_reg) + 1'b1;
    assign pos_p2 = (CNT_W+1)'(pos_reg) + 2'd2;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;

    assign sts.opcode     = op_reg;
    assign sts.full       = full;
    assign sts.empty      = (count_reg == '0);
    assign sts.match      = (rdata_reg == key_reg);
    assign sts.last_scan  = (pos_p1 == (CNT_W+1)'(count_reg));
    assign sts.last_shift = (pos_p2 == (CNT_W+1)'(count_reg));
    assign sts.out_free   = out_free;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FRONT: rd_addr = front_reg;
            RD_NEXT:  rd_addr = cur_inc;
            RD_SKIP:  rd_addr = cur_inc2;
            default:  rd_addr = front_reg;
        endcase

        wr_en   = 1'b1;
        wr_addr = cur_reg;
        wr_data = key_reg;
        case (cmd.wr_sel)
            WR_PREPEND: wr_addr = front_dec;
            WR_APPEND:  wr_addr = tail_slot;
            WR_SHIFT:   wr_data = rdata_reg;
            default:    wr_en   = 1'b0;
        endcase

        front_next = front_reg;
        case (cmd.front_op)
            PTR_INC: front_next = front_inc;
            PTR_DEC: front_next = front_dec;
            default: front_next = front_reg;
        endcase

        count_next = count_reg;
        case (cmd.count_op)
            PTR_INC: count_next = count_reg + 1'b1;
            PTR_DEC: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase

        pos_next = pos_reg;
        cur_next = cur_reg;
        case (cmd.scan_op)
            SCAN_START:
            begin
                pos_next = '0;
                cur_next = front_reg;
            end
            SCAN_STEP:
            begin
                pos_next = pos_reg + 1'b1;
                cur_next = cur_inc;
            end
            default:
            begin
                pos_next = pos_reg;
                cur_next = cur_reg;
            end
        endcase
    end

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            cur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            cur_reg   <= cur_next;
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= s_tdata[OPCODE_W-1:0];
            key_reg <= s_tdata[OPCODE_W +: ITEM_WIDTH];
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_item_reg   <= cmd.res_take_item ? rdata_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_item_reg   <= res_item_reg;
            out_length_reg <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({out_length_reg, out_item_reg, out_status_reg});

    `DQKD_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `DQKD_ASSERT(a_front_bound, clk, rst_n, front_reg <= IDX_W'(DEPTH - 1), "front index out of range")
    `DQKD_ASSERT_IMPL(a_no_grow_full, clk, rst_n, cmd.count_op == PTR_INC, !full, "insert into a full store")
    `DQKD_ASSERT_IMPL(a_out_free, clk, rst_n, cmd.out_load, out_free, "result overwrites an unread beat")

endmodule

`default_nettype wire

// ===== hw/rtl/deque_with_keyed_delete_core.sv =====
// ----------------------------------------------------------------------------
// deque_with_keyed_delete_core
// double-ended queue of item handles with delete and search by value
// ----------------------------------------------------------------------------
// sequence: prepend, append and unused opcodes go from decode to the result state,
//   dequeue reads the front entry first, search and delete walk the entries and a
//   delete hit shifts the rest down; throughput: one command at a time; the walk
//   reads one entry per cycle through the single read port of the store
// reset: asynchronous active low; store empty, front at zero, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_keyed_delete_core #(
    parameter int DEPTH      = dqkd_pkg::DQKD_DEPTH,
    parameter int ITEM_WIDTH = dqkd_pkg::DQKD_ITEM_WIDTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // opcode, item_in from bit 0 up
    input  wire logic [((dqkd_pkg::OPCODE_W+ITEM_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // status, item_out, length from bit 0 up
    output logic [((dqkd_pkg::STATUS_W+ITEM_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);
    import dqkd_pkg::*;

    dqkd_cmd_t cmd;
    dqkd_sts_t sts;

    dqkd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dqkd_datapath #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
